### src/dps_pkg.sv
package dps_pkg;

  // History depth and derived index widths
  localparam int MAX_DELAY = 64;
  localparam int AW        = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DLY_W     = 7;
  localparam int CW        = (DLY_W > $clog2(MAX_DELAY + 1)) ? DLY_W : $clog2(MAX_DELAY + 1);

  // Fixed-point constants
  localparam logic [31:0] START_POP   = 32'd737280;      // 180.0 in Q20.12
  localparam logic [31:0] EXP_M1      = 32'd1580030169;  // exp(-1) in Q0.32
  localparam logic [3:0]  TAYLOR_LAST = 4'd13;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BIRTH_RATE = 3'd0,
    REG_DEATH_RATE = 3'd1,
    REG_INV_SCALE  = 3'd2,
    REG_DELAY      = 3'd3,
    REG_BURN_IN    = 3'd4
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LAG,
    S_ELD,
    S_EA,
    S_EB,
    S_EC,
    S_ESUB,
    S_EP,
    S_EPW,
    S_B1,
    S_B2,
    S_B3,
    S_B4,
    S_B5,
    S_D2,
    S_D3
  } state_e;

  // floor(2^33 / k) for the Taylor term divisors
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] r;
    case (k)
      4'd2:    r = 33'd4294967296;
      4'd3:    r = 33'd2863311530;
      4'd4:    r = 33'd2147483648;
      4'd5:    r = 33'd1717986918;
      4'd6:    r = 33'd1431655765;
      4'd7:    r = 33'd1227133513;
      4'd8:    r = 33'd1073741824;
      4'd9:    r = 33'd954437176;
      4'd10:   r = 33'd858993459;
      4'd11:   r = 33'd780903144;
      4'd12:   r = 33'd715827882;
      4'd13:   r = 33'd660764199;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

### src/delayed_population_step.sv
// Step length from accepted word to result valid grows with n1 and n2, where n1 and n2
//   are the integer parts of the two exponent arguments; an argument of 32 or more skips its
//   series, and a waiting result holds write-back.
// Flow: one word at a time; the next word is taken after write-back.
//   One shared 33x33 multiplier runs every product, including the Taylor series divides.
// Reset: control and configuration registers at reset values, history reads as 180.0 through per-entry valid bits.
module delayed_population_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] birth_noise, [31:16] death_noise
  input  logic [0:0]  s_axis_tuser,   // [0] start_replicate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] population
);
  import dps_pkg::*;

  state_e state_q, state_d;

  logic [23:0] birth_q, death_q, inv_q;
  logic [DLY_W-1:0] dly_q;
  logic [15:0] burn_q;

  logic [31:0] mem [MAX_DELAY];
  logic [MAX_DELAY-1:0] vld_q;
  logic [AW-1:0] wp_q;
  logic [31:0] prev_q;
  logic [15:0] steps_q;
  logic [31:0] rd_q;
  logic        rd_vld_q;

  logic [15:0] bn_q, dn_q;
  logic        emit_q, phase_q;
  logic [31:0] lag_q, f_q, term_q, tq_q;
  logic [34:0] pos_q, neg_q;
  logic [3:0]  k_q;
  logic [4:0]  cnt_q;
  logic [32:0] r_q;
  logic [7:0]  thi_q;
  logic [47:0] acc_q;
  logic [43:0] bterm_q;
  logic        out_vld_q;
  logic [31:0] out_q;

  logic [32:0] mul_a, mul_b;
  logic [65:0] p_q;

  logic          in_acc, start, out_busy, wb_go;
  logic [AW-1:0] wp_eff, rd_addr;
  logic [CW-1:0] d_cl, wp_ext;
  logic [15:0]   steps_eff;
  logic [31:0]   lag_val;
  logic [51:0]   x_val;
  logic [31:0]   qh;
  logic [35:0]   rem;
  logic [31:0]   term_new;
  logic [55:0]   bfull;
  logic [44:0]   sum;
  logic [31:0]   pop_sat;
  logic          x_big;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign start    = s_axis_tuser[0];
  assign out_busy = out_vld_q && !m_axis_tready;
  assign wb_go    = (state_q == S_D3) && !(emit_q && out_busy);

  // Clamp the delay and form the lagged read address
  always_comb begin
    wp_eff = start ? '0 : wp_q;
    wp_ext = CW'(wp_eff);
    if (dly_q == '0) begin
      d_cl = CW'(1);
    end else if (CW'(dly_q) > CW'(MAX_DELAY)) begin
      d_cl = CW'(MAX_DELAY);
    end else begin
      d_cl = CW'(dly_q);
    end
    if (wp_ext >= d_cl) begin
      rd_addr = AW'(wp_ext - d_cl);
    end else begin
      rd_addr = AW'(wp_ext + CW'(MAX_DELAY) - d_cl);
    end
    steps_eff = start ? 16'd0 : steps_q;
  end

  // Datapath helpers around the product register
  always_comb begin
    lag_val  = rd_vld_q ? rd_q : START_POP;
    x_val    = phase_q ? {p_q[47:0], 4'b0} : p_q[55:4];
    x_big    = |x_val[51:37];
    qh       = p_q[64:33];
    rem      = {4'b0, tq_q} - (qh * k_q);
    term_new = (rem >= 36'(k_q)) ? qh + 32'd1 : qh;
    bfull    = {8'b0, acc_q} + {p_q[23:0], 32'b0};
    sum      = {1'b0, bterm_q} + {13'b0, p_q[63:32]};
    pop_sat  = (sum[44:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];
  end

  // Sequencer: next state and multiplier operands
  always_comb begin
    state_d       = state_q;
    mul_a         = '0;
    mul_b         = '0;
    s_axis_tready = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_LAG;
      end
      S_LAG: begin
        mul_a   = {1'b0, lag_val};
        mul_b   = {9'b0, inv_q};
        state_d = S_ELD;
      end
      S_ELD: begin
        if (x_big) state_d = phase_q ? S_D2 : S_B1;
        else state_d = S_EA;
      end
      S_EA: begin
        mul_a   = {1'b0, term_q};
        mul_b   = {1'b0, f_q};
        state_d = S_EB;
      end
      S_EB: begin
        mul_a   = {1'b0, p_q[63:32]};
        mul_b   = recip(k_q);
        state_d = S_EC;
      end
      S_EC: begin
        state_d = (k_q == TAYLOR_LAST) ? S_ESUB : S_EA;
      end
      S_ESUB: begin
        if (cnt_q == '0) state_d = phase_q ? S_D2 : S_B1;
        else state_d = S_EP;
      end
      S_EP: begin
        mul_a   = r_q;
        mul_b   = {1'b0, EXP_M1};
        state_d = S_EPW;
      end
      S_EPW: begin
        if (cnt_q == 5'd1) state_d = phase_q ? S_D2 : S_B1;
        else state_d = S_EP;
      end
      S_B1: begin
        mul_a   = {1'b0, lag_q};
        mul_b   = r_q;
        state_d = S_B2;
      end
      S_B2: begin
        mul_a   = {1'b0, p_q[63:32]};
        mul_b   = {9'b0, birth_q};
        state_d = S_B3;
      end
      S_B3: begin
        mul_a   = {1'b0, p_q[47:16]};
        mul_b   = {17'b0, bn_q};
        state_d = S_B4;
      end
      S_B4: begin
        mul_a   = {25'b0, thi_q};
        mul_b   = {17'b0, bn_q};
        state_d = S_B5;
      end
      S_B5: begin
        mul_a   = {9'b0, death_q};
        mul_b   = {17'b0, dn_q};
        state_d = S_ELD;
      end
      S_D2: begin
        mul_a   = {1'b0, prev_q};
        mul_b   = r_q;
        state_d = S_D3;
      end
      S_D3: begin
        // Hold the survival product while write-back waits
        mul_a   = {1'b0, prev_q};
        mul_b   = r_q;
        if (wb_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q <= 24'd425984;
      death_q <= 24'd10486;
      inv_q   <= 24'd41943;
      dly_q   <= DLY_W'(15);
      burn_q  <= 16'd0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BIRTH_RATE: birth_q <= cfg_data_i;
        REG_DEATH_RATE: death_q <= cfg_data_i;
        REG_INV_SCALE:  inv_q   <= cfg_data_i;
        REG_DELAY:      dly_q   <= cfg_data_i[DLY_W-1:0];
        REG_BURN_IN:    burn_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // History memory: write back at step end, read the lagged entry on accept
  always_ff @(posedge clk_i) begin
    if (wb_go) mem[wp_q] <= pop_sat;
    if (in_acc) rd_q <= mem[rd_addr];
  end

  // Replicate state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      wp_q      <= '0;
      prev_q    <= START_POP;
      steps_q   <= '0;
      rd_vld_q  <= 1'b0;
      emit_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (wb_go && emit_q) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      if (in_acc) begin
        rd_vld_q <= start ? 1'b0 : vld_q[rd_addr];
        emit_q   <= (steps_eff >= burn_q);
        steps_q  <= (steps_eff == 16'hFFFF) ? steps_eff : steps_eff + 16'd1;
        if (start) begin
          vld_q  <= '0;
          wp_q   <= '0;
          prev_q <= START_POP;
        end
      end
      if (wb_go) begin
        vld_q[wp_q] <= 1'b1;
        wp_q        <= (wp_q == AW'(MAX_DELAY - 1)) ? '0 : wp_q + AW'(1);
        prev_q      <= pop_sat;
      end
    end
  end

  // Arithmetic working registers
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (wb_go && emit_q) out_q <= pop_sat;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          bn_q <= s_axis_tdata[15:0];
          dn_q <= s_axis_tdata[31:16];
        end
      end
      S_LAG: begin
        lag_q   <= lag_val;
        phase_q <= 1'b0;
      end
      S_ELD: begin
        f_q    <= x_val[31:0];
        term_q <= x_val[31:0];
        pos_q  <= 35'h1_0000_0000;
        neg_q  <= {3'b0, x_val[31:0]};
        k_q    <= 4'd2;
        cnt_q  <= x_val[36:32];
        if (x_big) r_q <= '0;
      end
      S_EB: begin
        tq_q <= p_q[63:32];
      end
      S_EC: begin
        term_q <= term_new;
        if (k_q[0]) neg_q <= neg_q + {3'b0, term_new};
        else pos_q <= pos_q + {3'b0, term_new};
        k_q <= k_q + 4'd1;
      end
      S_ESUB: begin
        r_q <= (pos_q >= neg_q) ? 33'(pos_q - neg_q) : '0;
      end
      S_EPW: begin
        r_q   <= p_q[64:32];
        cnt_q <= cnt_q - 5'd1;
      end
      S_B3: begin
        thi_q <= p_q[55:48];
      end
      S_B4: begin
        acc_q <= p_q[47:0];
      end
      S_B5: begin
        bterm_q <= bfull[55:12];
        phase_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Accepted word blocks the input until write-back
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  // A result appears only out of write-back
  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_D3))
    else $error("result raised outside write-back");

  // Taylor index stays in range inside the series loop
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EA || state_q == S_EB || state_q == S_EC) |->
      (k_q >= 4'd2 && k_q <= TAYLOR_LAST))
    else $error("series index out of range");

endmodule

### verif/dps_checker.sv
`timescale 1ns / 1ps

module dps_checker
  import dps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] birth_noise, [31:16] death_noise
  input  logic [0:0]  s_axis_tuser,   // [0] start_replicate
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] population
  output int          fail_count_o,
  output int          pending_o,
  output int          pop_seen_o
);

  // Predictor copy of configuration and state
  logic [23:0] birth_rate_q, death_rate_q, inv_scale_q;
  logic [6:0]  delay_q;
  logic [15:0] burn_in_q;
  logic [31:0] hist_q [MAX_DELAY];
  int unsigned wr_ptr_q;
  logic [31:0] prev_pop_q;
  int unsigned steps_q;
  logic [31:0] pop_queue [$];

  assign pending_o = pop_queue.size();

  // exp(-x) in Q0.32 for x in Q32.32
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
    logic [63:0] n, f, term, pos, neg, r;
    n = x >> 32;
    f = x & 64'hFFFF_FFFF;
    term = 64'd1 << 32;
    pos = term;
    neg = 0;
    if (n >= 32) return 64'd0;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * f) >> 32) / k;
      if (k % 2) neg += term;
      else pos += term;
    end
    r = (pos >= neg) ? pos - neg : 64'd0;
    for (int k = 0; k < n; k++) r = (r * 64'd1580030169) >> 32;
    return r;
  endfunction

  task automatic refill_history();
    for (int i = 0; i < MAX_DELAY; i++) hist_q[i] = START_POP;
    prev_pop_q = START_POP;
    wr_ptr_q = 0;
    steps_q = 0;
  endtask

  // Advance one population step and queue the emitted value
  task automatic advance_population(input logic [15:0] bn, input logic [15:0] dn,
                                    input logic restart);
    int unsigned d, rd;
    logic [63:0] lag, t, s, sum;
    if (restart) refill_history();
    d = delay_q;
    if (d < 1) d = 1;
    if (d > MAX_DELAY) d = MAX_DELAY;
    rd = (wr_ptr_q + MAX_DELAY - d) % MAX_DELAY;
    lag = hist_q[rd];
    t = (lag * exp_neg_q32((lag * inv_scale_q) >> 4)) >> 32;
    t = (t * birth_rate_q) >> 16;
    t = (t * bn) >> 12;
    s = (64'(prev_pop_q) * exp_neg_q32((64'(death_rate_q) * dn) << 4)) >> 32;
    sum = t + s;
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    hist_q[wr_ptr_q] = sum[31:0];
    wr_ptr_q = (wr_ptr_q + 1) % MAX_DELAY;
    prev_pop_q = sum[31:0];
    if (steps_q >= burn_in_q) pop_queue.push_back(sum[31:0]);
    if (steps_q < 65535) steps_q++;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_rate_q <= 24'd425984;
      death_rate_q <= 24'd10486;
      inv_scale_q  <= 24'd41943;
      delay_q      <= 7'd15;
      burn_in_q    <= 16'd0;
      refill_history();
      pop_queue.delete();
      fail_count_o <= 0;
      pop_seen_o   <= 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_BIRTH_RATE: birth_rate_q <= cfg_data_i;
          REG_DEATH_RATE: death_rate_q <= cfg_data_i;
          REG_INV_SCALE:  inv_scale_q  <= cfg_data_i;
          REG_DELAY:      delay_q      <= cfg_data_i[6:0];
          REG_BURN_IN:    burn_in_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      // Predict on each accepted input word
      if (s_axis_tvalid && s_axis_tready)
        advance_population(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser[0]);
      // Compare each accepted result word
      if (m_axis_tvalid && m_axis_tready) begin
        pop_seen_o <= pop_seen_o + 1;
        if (pop_queue.size() == 0) begin
          $display("%0t: unexpected population word, expected none, actual %0d",
                   $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (m_axis_tdata !== pop_queue[0]) begin
            $display("%0t: population mismatch, expected %0d, actual %0d",
                     $time, pop_queue[0], m_axis_tdata);
            fail_count_o <= fail_count_o + 1;
          end
          void'(pop_queue.pop_front());
        end
      end
    end
  end

endmodule

### verif/tb_delayed_population_step.sv
`timescale 1ns / 1ps

module tb_delayed_population_step;
  import dps_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] birth_noise, [31:16] death_noise
  logic [0:0]  s_axis_tuser;   // [0] start_replicate
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] population
  int          fail_count, pending, pop_seen;
  int          cycle_count;
  int          words_sent;
  bit          calm_mode;

  delayed_population_step i_dut (.*);

  dps_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .pop_seen_o(pop_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver stalls at random except in calm stretches
  always @(posedge clk_i) begin
    m_axis_tready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 38);
  end

  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait for all results, then the worst-case step latency
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (260) @(posedge clk_i);
  endtask

  // Send one word, with a random idle gap before it unless in calm mode
  task automatic send_word(input logic [15:0] bn, input logic [15:0] dn, input logic rep);
    if (!calm_mode)
      while ($urandom_range(99) < 38) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dn, bn};
    s_axis_tuser  <= rep;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // Random phase under one setting; noise mostly near 1.0 to keep dynamics alive
  task automatic random_phase(input int count);
    logic [15:0] bn, dn;
    for (int i = 0; i < count; i++) begin
      bn = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048, 8192));
      dn = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048, 8192));
      send_word(bn, dn, $urandom_range(39) == 0);
    end
    idle_input();
  endtask

  initial begin
    logic [15:0] corner [4];
    corner = '{16'h0000, 16'h1000, 16'hFFFF, 16'h5555};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    calm_mode     = 1'b0;
    words_sent    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setting, noise extremes and a replicate restart
    for (int i = 0; i < 16; i++)
      send_word(corner[i % 4], corner[i / 4], i == 8);
    idle_input();
    drain();

    // Extreme rates, zero inverse scale, delay of one, burn-in across a restart
    write_reg(REG_BIRTH_RATE, 24'hFFFFFF);
    write_reg(REG_DEATH_RATE, 24'hFFFFFF);
    write_reg(REG_INV_SCALE, 24'd0);
    write_reg(REG_DELAY, 24'd1);
    write_reg(REG_BURN_IN, 24'd3);
    for (int i = 0; i < 8; i++)
      send_word(16'hFFFF, (i < 4) ? 16'h0000 : 16'h0001, i == 5);
    idle_input();
    drain();

    // Out-of-range delays and unused register index
    write_reg(REG_DELAY, 24'd0);
    cfg_we_i <= 1'b1; cfg_index_i <= 3'd7; cfg_data_i <= 24'hABCDEF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    write_reg(REG_BURN_IN, 24'd0);
    write_reg(REG_INV_SCALE, 24'hFFFFFF);
    write_reg(REG_DEATH_RATE, 24'd0);
    send_word(16'hFFFF, 16'hFFFF, 1'b1);
    idle_input();
    drain();
    write_reg(REG_DELAY, 24'd127);
    send_word(16'h1000, 16'h1000, 1'b0);
    idle_input();
    drain();

    // Random phases across settings; first one calm
    calm_mode = 1'b1;
    write_reg(REG_BIRTH_RATE, 24'd425984);
    write_reg(REG_DEATH_RATE, 24'd10486);
    write_reg(REG_INV_SCALE, 24'd41943);
    write_reg(REG_DELAY, 24'd15);
    random_phase(200);
    calm_mode = 1'b0;
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_BIRTH_RATE, 24'($urandom_range(1 << 20)));
      write_reg(REG_DEATH_RATE, 24'($urandom_range(1 << 17)));
      write_reg(REG_INV_SCALE, 24'($urandom_range(1, 1 << 18)));
      write_reg(REG_DELAY, 24'((p == 0) ? 64 : $urandom_range(1, 64)));
      write_reg(REG_BURN_IN, 24'((p == 2) ? 65535 : $urandom_range(0, 20)));
      random_phase(200);
      drain();
    end

    $display("sent %0d words over noise extremes, restarts, burn-in and delay limits",
             words_sent);
    $display("checked %0d population words", pop_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
